// ----- hdl/jsp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the Jacobi stencil point update block: widths, register
// indexes, transaction payload types and the pipeline stage payloads.
// Depends on nothing; every other file of the block uses it.
package jsp_pkg;

   // Field widths of values, weights and the change magnitude.
   localparam int ValueWidth   = 32;
   localparam int CoefWidth    = 16;
   localparam int CoefFracBits = 16;
   localparam int ChangeWidth  = 31;

   // Derived datapath widths.
   localparam int PairWidth    = ValueWidth + 1;
   localparam int ProductWidth = PairWidth + CoefWidth + 1;
   localparam int SumWidth     = ProductWidth + 2;
   localparam int ShiftedWidth = SumWidth - CoefFracBits;
   localparam int DiffWidth    = ValueWidth + 1;

   // Configuration register indexes.
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = ChangeWidth;

   typedef enum logic [CsrIndexWidth-1:0] {
      RegCoefX     = 2'd0,
      RegCoefY     = 2'd1,
      RegCoefZ     = 2'd2,
      RegTolerance = 2'd3
   } jsp_reg_type;

   // Reset values of the configuration registers.
   localparam logic [CoefWidth-1:0]   CoefXReset     = 16'd10923;
   localparam logic [CoefWidth-1:0]   CoefYReset     = 16'd10923;
   localparam logic [CoefWidth-1:0]   CoefZReset     = 16'd10922;
   localparam logic [ChangeWidth-1:0] ToleranceReset = 31'd66;

   // Saturation limits of the value format.
   localparam logic signed [ValueWidth-1:0] ValueMax = {1'b0, {(ValueWidth-1){1'b1}}};
   localparam logic signed [ValueWidth-1:0] ValueMin = {1'b1, {(ValueWidth-1){1'b0}}};

   typedef struct packed {
      logic [CoefWidth-1:0]   coef_x;
      logic [CoefWidth-1:0]   coef_y;
      logic [CoefWidth-1:0]   coef_z;
      logic [ChangeWidth-1:0] tolerance;
   } jsp_cfg_type;

   // Input transaction: the cell, its six neighbours and the sweep marker.
   typedef struct packed {
      logic signed [ValueWidth-1:0] center_value;
      logic signed [ValueWidth-1:0] west_value;
      logic signed [ValueWidth-1:0] east_value;
      logic signed [ValueWidth-1:0] south_value;
      logic signed [ValueWidth-1:0] north_value;
      logic signed [ValueWidth-1:0] front_value;
      logic signed [ValueWidth-1:0] back_value;
      logic                         last_in_sweep;
   } jsp_req_type;

   // Result transaction.
   typedef struct packed {
      logic signed [ValueWidth-1:0] new_value;
      logic [ChangeWidth-1:0]       max_change;
      logic                         sweep_end;
      logic                         converged;
   } jsp_rsp_type;

   // Payload after the weighting multipliers.
   typedef struct packed {
      logic signed [ValueWidth-1:0]   center_value;
      logic signed [ProductWidth-1:0] x_product;
      logic signed [ProductWidth-1:0] y_product;
      logic signed [ProductWidth-1:0] z_product;
      logic                           last_in_sweep;
   } jsp_prod_type;

   // Payload after the sum, truncation and saturation.
   typedef struct packed {
      logic signed [ValueWidth-1:0] center_value;
      logic signed [ValueWidth-1:0] new_value;
      logic                         last_in_sweep;
   } jsp_sum_type;

endpackage

// ----- hdl/jsp_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and result transactions
// of the Jacobi stencil point update block. Depends on jsp_pkg.
interface jsp_req_if;
   logic                  valid;
   logic                  ready;
   jsp_pkg::jsp_req_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface jsp_rsp_if;
   logic                  valid;
   logic                  ready;
   jsp_pkg::jsp_rsp_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/jsp_csr.sv -----
`timescale 1ns / 1ps
// Configuration registers of the Jacobi stencil point update block: the
// three pair weights and the convergence tolerance. Depends on jsp_pkg.
module jsp_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [jsp_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [jsp_pkg::CsrDataWidth-1:0]     csr_write_data,
   output jsp_pkg::jsp_cfg_type                 cfg
);

   jsp_pkg::jsp_cfg_type cfg_ff;
   jsp_pkg::jsp_cfg_type cfg_in;

   // Decode the register index and replace the addressed field.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (jsp_pkg::jsp_reg_type'(csr_index))
            jsp_pkg::RegCoefX: begin
               cfg_in.coef_x = csr_write_data[jsp_pkg::CoefWidth-1:0];
            end
            jsp_pkg::RegCoefY: begin
               cfg_in.coef_y = csr_write_data[jsp_pkg::CoefWidth-1:0];
            end
            jsp_pkg::RegCoefZ: begin
               cfg_in.coef_z = csr_write_data[jsp_pkg::CoefWidth-1:0];
            end
            jsp_pkg::RegTolerance: begin
               cfg_in.tolerance = csr_write_data[jsp_pkg::ChangeWidth-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_x    <= jsp_pkg::CoefXReset;
         cfg_ff.coef_y    <= jsp_pkg::CoefYReset;
         cfg_ff.coef_z    <= jsp_pkg::CoefZReset;
         cfg_ff.tolerance <= jsp_pkg::ToleranceReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/jsp_product_stage.sv -----
`timescale 1ns / 1ps
// First arithmetic stage: forms the three neighbour pair sums and weights
// each by its coefficient, one multiplier per axis. Depends on jsp_pkg.
module jsp_product_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic                   in_valid,
   input  jsp_pkg::jsp_req_type   in_data,
   input  jsp_pkg::jsp_cfg_type   cfg,
   output logic                   out_valid,
   output jsp_pkg::jsp_prod_type  out_data
);

   logic signed [jsp_pkg::PairWidth-1:0] x_pair;
   logic signed [jsp_pkg::PairWidth-1:0] y_pair;
   logic signed [jsp_pkg::PairWidth-1:0] z_pair;
   logic                                 valid_ff;
   logic                                 valid_in;
   jsp_pkg::jsp_prod_type                data_ff;
   jsp_pkg::jsp_prod_type                data_in;

   // Pair sums are exact in one extra bit.
   assign x_pair = {in_data.west_value[jsp_pkg::ValueWidth-1], in_data.west_value}
                 + {in_data.east_value[jsp_pkg::ValueWidth-1], in_data.east_value};
   assign y_pair = {in_data.south_value[jsp_pkg::ValueWidth-1], in_data.south_value}
                 + {in_data.north_value[jsp_pkg::ValueWidth-1], in_data.north_value};
   assign z_pair = {in_data.front_value[jsp_pkg::ValueWidth-1], in_data.front_value}
                 + {in_data.back_value[jsp_pkg::ValueWidth-1], in_data.back_value};

   // The weights are unsigned, so they enter the signed product with a zero on top.
   always_comb begin
      data_in.center_value  = in_data.center_value;
      data_in.x_product     = x_pair * $signed({1'b0, cfg.coef_x});
      data_in.y_product     = y_pair * $signed({1'b0, cfg.coef_y});
      data_in.z_product     = z_pair * $signed({1'b0, cfg.coef_z});
      data_in.last_in_sweep = in_data.last_in_sweep;
      valid_in              = load ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- hdl/jsp_sum_stage.sv -----
`timescale 1ns / 1ps
// Second arithmetic stage: adds the three weighted pairs, drops the weight
// fraction bits towards minus infinity and saturates. Depends on jsp_pkg.
module jsp_sum_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic                   in_valid,
   input  jsp_pkg::jsp_prod_type  in_data,
   output logic                   out_valid,
   output jsp_pkg::jsp_sum_type   out_data
);

   localparam int TopBits = jsp_pkg::ShiftedWidth - jsp_pkg::ValueWidth + 1;

   logic signed [jsp_pkg::SumWidth-1:0]     full_sum;
   logic signed [jsp_pkg::ShiftedWidth-1:0] shifted;
   logic [TopBits-1:0]                      top_bits;
   logic                                    valid_ff;
   logic                                    valid_in;
   jsp_pkg::jsp_sum_type                    data_ff;
   jsp_pkg::jsp_sum_type                    data_in;

   // Exact sum of the three products.
   assign full_sum = jsp_pkg::SumWidth'(in_data.x_product)
                   + jsp_pkg::SumWidth'(in_data.y_product)
                   + jsp_pkg::SumWidth'(in_data.z_product);

   // Dropping the low bits of a two's complement word is a floor division.
   assign shifted  = full_sum[jsp_pkg::SumWidth-1:jsp_pkg::CoefFracBits];
   assign top_bits = shifted[jsp_pkg::ShiftedWidth-1:jsp_pkg::ValueWidth-1];

   // Saturate when the bits above the value's sign are not all copies of it.
   always_comb begin
      data_in.center_value  = in_data.center_value;
      data_in.last_in_sweep = in_data.last_in_sweep;
      if (top_bits == '0 || top_bits == '1) begin
         data_in.new_value = shifted[jsp_pkg::ValueWidth-1:0];
      end else if (shifted[jsp_pkg::ShiftedWidth-1]) begin
         data_in.new_value = jsp_pkg::ValueMin;
      end else begin
         data_in.new_value = jsp_pkg::ValueMax;
      end
      valid_in = load ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- hdl/jsp_update_stage.sv -----
`timescale 1ns / 1ps
// Last stage: change magnitude, running sweep maximum, convergence flag and
// the result register that drives the result channel. Depends on jsp_pkg.
module jsp_update_stage (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  logic                                 in_valid,
   input  jsp_pkg::jsp_sum_type                 in_data,
   input  logic [jsp_pkg::ChangeWidth-1:0]      tolerance,
   output logic                                 out_valid,
   output jsp_pkg::jsp_rsp_type                 out_data
);

   logic signed [jsp_pkg::DiffWidth-1:0] diff;
   logic [jsp_pkg::DiffWidth-1:0]        magnitude;
   logic [jsp_pkg::ChangeWidth-1:0]      change;
   logic [jsp_pkg::ChangeWidth-1:0]      running_max;
   logic [jsp_pkg::ChangeWidth-1:0]      sweep_max_ff;
   logic [jsp_pkg::ChangeWidth-1:0]      sweep_max_in;
   logic                                 valid_ff;
   logic                                 valid_in;
   jsp_pkg::jsp_rsp_type                 result_ff;
   jsp_pkg::jsp_rsp_type                 result_in;
   logic                                 take;

   assign take = load && in_valid;

   // Exact difference and its magnitude, saturated to the change width.
   assign diff = {in_data.new_value[jsp_pkg::ValueWidth-1], in_data.new_value}
               - {in_data.center_value[jsp_pkg::ValueWidth-1], in_data.center_value};
   assign magnitude = diff[jsp_pkg::DiffWidth-1] ? -diff : diff;
   assign change = (magnitude[jsp_pkg::DiffWidth-1:jsp_pkg::ChangeWidth] != '0)
                 ? '1 : magnitude[jsp_pkg::ChangeWidth-1:0];

   // Running maximum including this cell; a sweep's last cell clears it.
   always_comb begin
      running_max = (change > sweep_max_ff) ? change : sweep_max_ff;
      result_in.new_value  = in_data.new_value;
      result_in.max_change = running_max;
      result_in.sweep_end  = in_data.last_in_sweep;
      result_in.converged  = in_data.last_in_sweep && (running_max < tolerance);
      sweep_max_in = sweep_max_ff;
      if (take) begin
         sweep_max_in = in_data.last_in_sweep ? '0 : running_max;
      end
      valid_in = load ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         sweep_max_ff <= '0;
      end else begin
         valid_ff     <= valid_in;
         sweep_max_ff <= sweep_max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = result_ff;

`ifndef SYNTHESIS
   // The last cell of a sweep leaves the stored maximum cleared.
   a_sweep_clear: assert property (@(posedge clock) disable iff (reset)
      (take && in_data.last_in_sweep) |=> (sweep_max_ff == '0))
      else $error("sweep maximum not cleared after the last cell of a sweep");

   // Inside a sweep the stored maximum equals the reported one.
   a_sweep_track: assert property (@(posedge clock) disable iff (reset)
      (take && !in_data.last_in_sweep) |=> (sweep_max_ff == result_ff.max_change))
      else $error("stored sweep maximum differs from the reported maximum");

   // The maximum moves only when a transaction passes through this stage.
   a_sweep_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> (sweep_max_ff == $past(sweep_max_ff)))
      else $error("sweep maximum changed without a transaction");

   // Convergence is reported only on a result that closes a sweep.
   a_conv_at_end: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && result_ff.converged) |-> result_ff.sweep_end)
      else $error("converged flagged on a result that does not close a sweep");
`endif

endmodule

// ----- hdl/jacobi_stencil_point_update.sv -----
`timescale 1ns / 1ps
// Top level of the Jacobi stencil point update block: input register,
// weighting, sum and update stages, and the configuration registers.
// Depends on jsp_pkg, jsp_if, jsp_csr and the three stage modules.
//
// The block computes one point of a 3D Jacobi sweep with a seven-point
// stencil: new = coef_x*(west+east) + coef_y*(south+north)
// + coef_z*(front+back), truncated towards minus infinity and saturated to
// the signed 32-bit value format, while it tracks the largest absolute
// change of the sweep and reports convergence against the tolerance on the
// cell marked last of a sweep. It accepts one transaction every clock and
// presents its result once it has moved from the input register through
// the product and sum registers into the result register; the pipeline
// stalls only when the result channel withholds ready. Values and tolerance
// share one fixed point format (Q16.16 by default); the datapath does not
// depend on where the value's binary point sits, since the weights are
// Q0.16. Configuration writes take effect on the next clock and belong in
// idle periods.
module jacobi_stencil_point_update (
   input  logic                                 clock,
   input  logic                                 reset,
   jsp_req_if.sink                              req_if,
   jsp_rsp_if.source                            rsp_if,
   input  logic                                 csr_write_enable,
   input  logic [jsp_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [jsp_pkg::CsrDataWidth-1:0]     csr_write_data
);

   jsp_pkg::jsp_cfg_type  cfg;
   logic                  s0_valid_ff;
   logic                  s0_valid_in;
   jsp_pkg::jsp_req_type  s0_data_ff;
   logic                  s1_valid;
   jsp_pkg::jsp_prod_type s1_data;
   logic                  s2_valid;
   jsp_pkg::jsp_sum_type  s2_data;
   logic                  s3_valid;
   logic                  s0_free;
   logic                  s1_free;
   logic                  s2_free;
   logic                  s3_free;

   // A stage may load when it is empty or its contents move on this clock.
   assign s3_free = !s3_valid || rsp_if.ready;
   assign s2_free = !s2_valid || s3_free;
   assign s1_free = !s1_valid || s2_free;
   assign s0_free = !s0_valid_ff || s1_free;

   assign req_if.ready = s0_free;

   // Input register.
   assign s0_valid_in = s0_free ? req_if.valid : s0_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_free && req_if.valid) begin
         s0_data_ff <= req_if.data;
      end
   end

   jsp_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   jsp_product_stage u_product (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_free),
      .in_valid  (s0_valid_ff),
      .in_data   (s0_data_ff),
      .cfg       (cfg),
      .out_valid (s1_valid),
      .out_data  (s1_data)
   );

   jsp_sum_stage u_sum (
      .clock     (clock),
      .reset     (reset),
      .load      (s2_free),
      .in_valid  (s1_valid),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_data  (s2_data)
   );

   jsp_update_stage u_update (
      .clock     (clock),
      .reset     (reset),
      .load      (s3_free),
      .in_valid  (s2_valid),
      .in_data   (s2_data),
      .tolerance (cfg.tolerance),
      .out_valid (s3_valid),
      .out_data  (rsp_if.data)
   );

   assign rsp_if.valid = s3_valid;

endmodule
